// File: rtl/iucc_pkg.sv
// Package: shared types, constants and state codes for the interval coverage counter.
package iucc_pkg;

    localparam int MAX_INTERVALS = 64;
    localparam int COORD_BITS    = 32;
    localparam int IDX_BITS      = $clog2(MAX_INTERVALS);
    localparam int CNT_BITS      = $clog2(MAX_INTERVALS + 1);
    localparam int TOTAL_BITS    = COORD_BITS + 1;
    localparam int ENTRY_BITS    = 2 * COORD_BITS;

    localparam logic [1:0] STATUS_ADDED = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_BAD   = 2'd2;

    typedef struct packed {
        logic [31:0] range_start;
        logic [31:0] range_end;
    } iucc_in_t;

    typedef struct packed {
        logic [32:0] covered_total;
        logic [6:0]  entry_count;
        logic [1:0]  status;
    } iucc_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_OVL_RD,
        ST_OVL_CHK,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_FINISH
    } iucc_state_t;

endpackage

// File: rtl/iucc_ram.sv
// Generic single-port RAM with registered read data.
module iucc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: rtl/interval_union_coverage_counter.sv
// Top level: interval union coverage counter with a sorted interval table in RAM.
//
// Each transfer with start not above end adds one closed range [range_start,
// range_end] to a sorted table of disjoint intervals held in one RAM (start and end
// packed per entry), unless the table is full and the range overlaps no entry; every
// transfer returns one result with the covered point total, the entry count and a
// status. An add takes a linear search past the entries that end below the range,
// then absorbs the overlapping entries, then moves entries while the table is opened
// or closed (with exactly one absorbed entry the entries above it are rewritten in
// place). A range with start above end has its result in the cycle after the
// accepting edge, and the block returns to idle after the finish state. The result
// strobe is high for exactly one cycle and cannot be stalled; busy stays high from
// the accepting edge until the result cycle is over.
module interval_union_coverage_counter
    import iucc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  iucc_in_t  cmd,
    output logic      done,
    output iucc_out_t result
);

    iucc_state_t state_reg, state_next;

    logic [COORD_BITS-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [CNT_BITS-1:0]   n_reg, n_next;      // stored entries
    logic [CNT_BITS-1:0]   pos_reg, pos_next;  // insertion point
    logic [CNT_BITS-1:0]   k_reg, k_next;      // absorbed entries
    logic [CNT_BITS-1:0]   ptr_reg, ptr_next;  // scan / move pointer
    logic [TOTAL_BITS-1:0] sum_reg, sum_next;
    logic                  done_reg, done_next;
    logic [1:0]            stat_reg, stat_next;

    logic                  ram_we;
    logic [IDX_BITS-1:0]   ram_addr;
    logic [ENTRY_BITS-1:0] ram_wdata, ram_rdata, hold_reg, hold_next;
    logic [COORD_BITS-1:0] rd_start, rd_end;

    assign rd_start = ram_rdata[ENTRY_BITS-1:COORD_BITS];
    assign rd_end   = ram_rdata[COORD_BITS-1:0];

    iucc_ram #(.WIDTH(ENTRY_BITS), .DEPTH(MAX_INTERVALS)) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            sum_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            sum_reg   <= sum_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        pos_reg  <= pos_next;
        k_reg    <= k_next;
        ptr_reg  <= ptr_next;
        stat_reg <= stat_next;
        hold_reg <= hold_next;
    end

    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        n_next     = n_reg;
        pos_next   = pos_reg;
        k_next     = k_reg;
        ptr_next   = ptr_reg;
        sum_next   = sum_reg;
        stat_next  = stat_reg;
        hold_next  = hold_reg;
        done_next  = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = ptr_reg[IDX_BITS-1:0];
        ram_wdata  = hold_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    lo_next  = cmd.range_start;
                    hi_next  = cmd.range_end;
                    ptr_next = '0;
                    k_next   = '0;
                    if (cmd.range_start > cmd.range_end)
                    begin
                        // drop malformed range, report current state
                        stat_next  = STATUS_BAD;
                        done_next  = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SRCH_RD;
                    end
                end
            end

            // search: first entry whose end is not below lo
            ST_SRCH_RD:
            begin
                if (ptr_reg == n_reg)
                begin
                    pos_next   = ptr_reg;
                    state_next = ST_OVL_CHK;
                end
                else
                begin
                    state_next = ST_SRCH_CHK;
                end
            end

            ST_SRCH_CHK:
            begin
                if (rd_end < lo_reg)
                begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = ST_SRCH_RD;
                end
                else
                begin
                    pos_next   = ptr_reg;
                    state_next = ST_OVL_RD;
                    // entry already read: evaluate it directly
                    if (rd_start <= hi_reg)
                    begin
                        if (k_reg == '0 && rd_start < lo_reg)
                        begin
                            lo_next = rd_start;
                        end
                        if (rd_end > hi_reg)
                        begin
                            hi_next = rd_end;
                        end
                        sum_next = sum_reg - (TOTAL_BITS'(rd_end) - TOTAL_BITS'(rd_start)
                                   + 1'b1);
                        k_next   = k_reg + 1'b1;
                        ptr_next = ptr_reg + 1'b1;
                    end
                    else
                    begin
                        state_next = ST_OVL_CHK;
                    end
                end
            end

            // absorb overlapping entries that follow without a gap
            ST_OVL_RD:
            begin
                if (ptr_reg == n_reg)
                begin
                    state_next = ST_OVL_CHK;
                end
                else
                begin
                    state_next = ST_OVL_CHK;
                    k_next     = k_reg;
                    hold_next  = '1; // mark: read issued
                end
            end

            ST_OVL_CHK:
            begin
                if (hold_reg == '1 && ptr_reg != n_reg && rd_start <= hi_reg)
                begin
                    if (rd_end > hi_reg)
                    begin
                        hi_next = rd_end;
                    end
                    sum_next   = sum_reg - (TOTAL_BITS'(rd_end) - TOTAL_BITS'(rd_start)
                                 + 1'b1);
                    k_next     = k_reg + 1'b1;
                    ptr_next   = ptr_reg + 1'b1;
                    hold_next  = '0;
                    state_next = ST_OVL_RD;
                end
                else if (k_reg == '0 && n_reg == CNT_BITS'(MAX_INTERVALS))
                begin
                    stat_next  = STATUS_FULL;
                    done_next  = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    hold_next = '0;
                    stat_next = STATUS_ADDED;
                    if (k_reg == '0)
                    begin
                        // open a slot: move entries up, top first
                        ptr_next = n_reg;
                        n_next   = n_reg + 1'b1;
                    end
                    else
                    begin
                        // close the gap: move entries down
                        ptr_next = pos_reg + k_reg;
                        n_next   = n_reg - k_reg + 1'b1;
                    end
                    state_next = ST_MOVE_RD;
                end
            end

            ST_MOVE_RD:
            begin
                if (k_reg == '0)
                begin
                    if (ptr_reg == pos_reg)
                    begin
                        state_next = ST_MOVE_WR;
                    end
                    else
                    begin
                        ram_addr   = IDX_BITS'(ptr_reg - 1'b1);
                        state_next = ST_MOVE_WR;
                    end
                end
                else
                begin
                    if (ptr_reg >= n_reg + k_reg - 1'b1)
                    begin
                        ptr_next = pos_reg;
                    end
                    state_next = ST_MOVE_WR;
                end
            end

            ST_MOVE_WR:
            begin
                if (k_reg == '0 && ptr_reg != pos_reg)
                begin
                    ram_we     = 1'b1;
                    ram_addr   = ptr_reg[IDX_BITS-1:0];
                    ram_wdata  = ram_rdata;
                    ptr_next   = ptr_reg - 1'b1;
                    state_next = ST_MOVE_RD;
                end
                else if (k_reg != '0 && ptr_reg != pos_reg)
                begin
                    ram_we     = 1'b1;
                    ram_addr   = IDX_BITS'(ptr_reg - k_reg + 1'b1);
                    ram_wdata  = ram_rdata;
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = ST_MOVE_RD;
                end
                else
                begin
                    // write the widened range at its slot
                    ram_we     = 1'b1;
                    ram_addr   = pos_reg[IDX_BITS-1:0];
                    ram_wdata  = {lo_reg, hi_reg};
                    sum_next   = sum_reg + (TOTAL_BITS'(hi_reg) - TOTAL_BITS'(lo_reg) + 1'b1);
                    done_next  = 1'b1;
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy                 = (state_reg != ST_IDLE);
    assign done                 = done_reg;
    assign result.covered_total = sum_reg;
    assign result.entry_count   = 7'(n_reg);
    assign result.status        = stat_reg;

    // result strobe comes only in the cycle after an add or a drop decision
    assert property (@(posedge clk) disable iff (!rst_n) done |-> state_reg == ST_FINISH)
        else $error("result strobe outside finish state");

    // the table never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CNT_BITS'(MAX_INTERVALS))
        else $error("entry count above table depth");

    // a dropped item leaves the count unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        done && stat_reg != STATUS_ADDED |-> $stable(n_reg))
        else $error("drop changed entry count");

endmodule
